>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the packed index unpacker.
// Relies on the house clock and reset names: clock, reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("invariant violated");
`define ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication violated");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

>>> rtl/piu_pkg.sv
// Types, codes and helper functions of the packed index unpacker.
// No dependencies; used by packed_index_unpacker_unit.
`default_nettype none

package piu_pkg;

   localparam int MAX_ENTRY_BITS = 16;
   localparam int WORD_BITS      = 64;
   localparam int CARRY_BITS     = MAX_ENTRY_BITS - 1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_data_type;

   typedef struct packed {
      logic [15:0] entry_value;
      logic        last_entry;
      logic [2:0]  error_code;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_NO_DATA   = 3'd1,
      ERR_SHORT     = 3'd2,
      ERR_LONG      = 3'd3,
      ERR_PALETTE   = 3'd4,
      ERR_ZERO_SIZE = 3'd5
   } err_code_type;

   typedef enum logic [2:0] {
      CSR_PALETTE_SIZE = 3'd0,
      CSR_SIZE_X       = 3'd1,
      CSR_SIZE_Y       = 3'd2,
      CSR_SIZE_Z       = 3'd3,
      CSR_DATA_LENGTH  = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_XY,
      ST_MUL_Z,
      ST_MUL_W,
      ST_JUDGE,
      ST_ERROR,
      ST_LOAD,
      ST_EMIT,
      ST_FINISH
   } state_type;

   // Entry width = bit length of (palette - 1); zero marks a palette out of range.
   function automatic logic [4:0] entry_width(input logic [16:0] palette);
      logic [16:0] span;
      logic [4:0]  w;
      span = palette - 17'd1;
      w    = '0;
      if (palette >= 17'd2 && palette <= 17'(1 << MAX_ENTRY_BITS)) begin
         for (int i = 0; i < MAX_ENTRY_BITS; i++) begin
            if (span[i]) w = 5'(i + 1);
         end
      end
      return w;
   endfunction

   function automatic logic [15:0] low_mask(input logic [4:0] n);
      logic [16:0] full;
      full = (17'd1 << n) - 17'd1;
      return (n >= 5'(MAX_ENTRY_BITS)) ? 16'hFFFF : full[15:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/packed_index_unpacker_unit.sv
// Packed index unpacker: top level, sequencer, shared multiplier and shifter.
// Depends on piu_pkg and assert_macros.svh.
//
// Usage:
//  - Request channel (req_valid/req_stall/req_data) carries one packed byte per
//    request; 64-bit words arrive most significant byte first, final_byte marks
//    the last byte of an array. Entries are read LSB first as one bit stream.
//  - Result channel (rsp_valid/rsp_stall/rsp_data) gives one unpacked entry per
//    transfer, or a single error result (value zero, last_entry set).
//  - CSR port (csr_write_en/csr_index/csr_wdata) sets palette size, extents and
//    data length; any write to a listed register abandons an array in flight.
//  - Throughput: one request at a time. A byte that does not finish a word
//    goes through load and finish; one that finishes a word (or the array)
//    also goes through emit, one entry per cycle via the shared shifter while
//    the receiver does not stall. The first byte of an array first runs the
//    configuration check on the shared 30x10 multiplier (x*y, *z, *width,
//    compare), error or not. The byte, the word and each entry are registered.
//  - Reset: synchronous, active high; clears the stream state and restores the
//    register defaults (palette 2, extents 1, length 0).
//  - A stalled receiver freezes entry emission; the result register holds.
`default_nettype none
`include "assert_macros.svh"

module packed_index_unpacker_unit
   import piu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire req_data_type req_data,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_data_type rsp_data,
   input  wire logic         csr_write_en,
   input  wire logic [2:0]   csr_index,
   input  wire logic [23:0]  csr_wdata
);

   // Configuration registers
   logic [16:0] palette_ff, palette_in;
   logic [9:0]  size_x_ff, size_x_in;
   logic [9:0]  size_y_ff, size_y_in;
   logic [9:0]  size_z_ff, size_z_in;
   logic [23:0] length_ff, length_in;

   // Sequencer and stream state
   state_type             state_ff, state_in;
   logic [63:0]           gather_ff, gather_in;
   logic [2:0]            slot_ff, slot_in;
   logic [CARRY_BITS-1:0] carry_bits_ff, carry_bits_in;
   logic [3:0]            carry_count_ff, carry_count_in;
   logic [29:0]           entries_ff, entries_in;
   logic                  checked_ff, checked_in;
   logic                  fault_ff, fault_in;

   // Working registers of the current request
   logic [7:0]  byte_ff, byte_in;
   logic        final_ff, final_in;
   logic [4:0]  width_ff, width_in;
   logic [29:0] vol_ff, vol_in;
   logic [39:0] prod_ff, prod_in;
   logic [6:0]  nbits_ff, nbits_in;
   logic [6:0]  wpos_ff, wpos_in;
   logic [2:0]  err_ff, err_in;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   // Shared multiplier operands
   logic [29:0] mul_a;
   logic [9:0]  mul_b;
   logic [39:0] mul_p;

   // Shared shift/extract unit
   logic [63:0] shifted;
   logic [15:0] field;
   logic [4:0]  need;
   logic [7:0]  have;
   logic [6:0]  rem;
   logic        more;
   logic [15:0] part;
   logic [15:0] value;
   logic [15:0] carry_add;

   // Check arithmetic
   logic [35:0] bits_avail;
   logic [35:0] bits_need;

   logic out_free;
   logic req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      shifted    = gather_ff >> wpos_ff;
      field      = shifted[15:0];
      need       = width_ff - {1'b0, carry_count_ff};
      rem        = nbits_ff - wpos_ff;
      have       = {1'b0, rem} + {4'b0, carry_count_ff};
      more       = (entries_ff < vol_ff) && (have >= {3'b0, width_ff});
      part       = field & low_mask(need);
      value      = ({1'b0, carry_bits_ff} | (part << carry_count_ff)) & low_mask(width_ff);
      carry_add  = (field & low_mask(rem[4:0])) << carry_count_ff;
      bits_avail = {9'b0, length_ff, 3'b000};
      bits_need  = {1'b0, prod_ff[34:0]};
   end

   always_comb begin
      case (state_ff)
         ST_MUL_XY: begin
            mul_a = {20'b0, size_x_ff};
            mul_b = size_y_ff;
         end
         ST_MUL_Z: begin
            mul_a = prod_ff[29:0];
            mul_b = size_z_ff;
         end
         ST_MUL_W: begin
            mul_a = prod_ff[29:0];
            mul_b = {5'b0, width_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      // full-width product: volume times width needs up to 34 bits
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      // hold everything by default
      palette_in     = palette_ff;
      size_x_in      = size_x_ff;
      size_y_in      = size_y_ff;
      size_z_in      = size_z_ff;
      length_in      = length_ff;
      state_in       = state_ff;
      gather_in      = gather_ff;
      slot_in        = slot_ff;
      carry_bits_in  = carry_bits_ff;
      carry_count_in = carry_count_ff;
      entries_in     = entries_ff;
      checked_in     = checked_ff;
      fault_in       = fault_ff;
      byte_in        = byte_ff;
      final_in       = final_ff;
      width_in       = width_ff;
      vol_in         = vol_ff;
      prod_in        = prod_ff;
      nbits_in       = nbits_ff;
      wpos_in        = wpos_ff;
      err_in         = err_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               byte_in  = req_data.data_byte;
               final_in = req_data.final_byte;
               if (!checked_ff) begin
                  width_in = entry_width(palette_ff);
                  state_in = ST_MUL_XY;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_MUL_XY: begin
            prod_in  = mul_p;
            state_in = ST_MUL_Z;
         end
         ST_MUL_Z: begin
            prod_in  = mul_p;
            state_in = ST_MUL_W;
         end
         ST_MUL_W: begin
            vol_in   = prod_ff[29:0];
            prod_in  = mul_p;
            state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            checked_in = 1'b1;
            if (width_ff == 5'd0) begin
               err_in = ERR_PALETTE;
            end else if (size_x_ff == 10'd0 || size_y_ff == 10'd0 || size_z_ff == 10'd0) begin
               err_in = ERR_ZERO_SIZE;
            end else if (length_ff == 24'd0) begin
               err_in = ERR_NO_DATA;
            end else if (bits_avail < bits_need) begin
               err_in = ERR_SHORT;
            end else if (bits_avail > bits_need + 36'(WORD_BITS)) begin
               err_in = ERR_LONG;
            end else begin
               err_in = ERR_NONE;
            end
            if (err_in != ERR_NONE) begin
               fault_in = 1'b1;
               state_in = ST_ERROR;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.entry_value = '0;
               rsp_data_in.last_entry  = 1'b1;
               rsp_data_in.error_code  = err_ff;
               state_in                = ST_FINISH;
            end
         end
         ST_LOAD: begin
            if (fault_ff) begin
               state_in = ST_FINISH;
            end else begin
               gather_in = {gather_ff[55:0], byte_ff};
               slot_in   = slot_ff + 3'd1;
               wpos_in   = '0;
               nbits_in  = {1'b0, slot_ff + 3'd1, 3'b000};
               if (slot_ff == 3'd7) begin
                  nbits_in = 7'(WORD_BITS);
                  state_in = ST_EMIT;
               end else if (final_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_EMIT: begin
            if (more) begin
               if (out_free) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.entry_value = value;
                  rsp_data_in.last_entry  = (entries_ff + 30'd1 == vol_ff);
                  rsp_data_in.error_code  = ERR_NONE;
                  wpos_in                 = wpos_ff + {2'b0, need};
                  carry_bits_in           = '0;
                  carry_count_in          = '0;
                  entries_in              = entries_ff + 30'd1;
               end
            end else begin
               // keep the leftover bits for the next word
               if (entries_ff >= vol_ff) begin
                  carry_bits_in  = '0;
                  carry_count_in = '0;
               end else begin
                  carry_bits_in  = carry_bits_ff | carry_add[CARRY_BITS-1:0];
                  carry_count_in = carry_count_ff + rem[3:0];
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_ff == 3'd0) gather_in = '0;
            if (final_ff) begin
               gather_in      = '0;
               slot_in        = '0;
               carry_bits_in  = '0;
               carry_count_in = '0;
               entries_in     = '0;
               checked_in     = 1'b0;
               fault_in       = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // writes to the listed registers restart the stream
      if (csr_write_en) begin
         case (csr_index)
            CSR_PALETTE_SIZE: palette_in = csr_wdata[16:0];
            CSR_SIZE_X:       size_x_in  = csr_wdata[9:0];
            CSR_SIZE_Y:       size_y_in  = csr_wdata[9:0];
            CSR_SIZE_Z:       size_z_in  = csr_wdata[9:0];
            CSR_DATA_LENGTH:  length_in  = csr_wdata;
            default: ;
         endcase
         if (csr_index <= CSR_DATA_LENGTH) begin
            gather_in      = '0;
            slot_in        = '0;
            carry_bits_in  = '0;
            carry_count_in = '0;
            entries_in     = '0;
            checked_in     = 1'b0;
            fault_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff     <= 17'd2;
         size_x_ff      <= 10'd1;
         size_y_ff      <= 10'd1;
         size_z_ff      <= 10'd1;
         length_ff      <= '0;
         state_ff       <= ST_IDLE;
         gather_ff      <= '0;
         slot_ff        <= '0;
         carry_bits_ff  <= '0;
         carry_count_ff <= '0;
         entries_ff     <= '0;
         checked_ff     <= 1'b0;
         fault_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         palette_ff     <= palette_in;
         size_x_ff      <= size_x_in;
         size_y_ff      <= size_y_in;
         size_z_ff      <= size_z_in;
         length_ff      <= length_in;
         state_ff       <= state_in;
         gather_ff      <= gather_in;
         slot_ff        <= slot_in;
         carry_bits_ff  <= carry_bits_in;
         carry_count_ff <= carry_count_in;
         entries_ff     <= entries_in;
         checked_ff     <= checked_in;
         fault_ff       <= fault_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      final_ff    <= final_in;
      width_ff    <= width_in;
      vol_ff      <= vol_in;
      prod_ff     <= prod_in;
      nbits_ff    <= nbits_in;
      wpos_ff     <= wpos_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_IMPLY(a_carry_below_width, state_ff == ST_EMIT, carry_count_ff < width_ff)
   `ASSERT_IMPLY(a_entries_bounded, checked_ff && !fault_ff, entries_ff <= vol_ff)
   `ASSERT_IMPLY(a_fault_needs_check, fault_ff, checked_ff)
   `ASSERT_IMPLY(a_error_result_shape, rsp_valid_ff && rsp_data_ff.error_code != ERR_NONE, rsp_data_ff.last_entry && rsp_data_ff.entry_value == 16'd0)

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for packed_index_unpacker_unit: bytes in, unpacked palette ids out.
// Depends on piu_pkg for the request/result structs, error codes and register indexes.
// Holds its own bit-true predictor in a small scoreboard class; plain tasks drive the ports.
module testbench;
   import piu_pkg::*;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int SETTLE_CYCLES  = 40;    // a byte with no entries finishes well within this
   localparam int RANDOM_TARGET  = 370;
   localparam int HOLD_OFF_LEN   = 400;

   // Unpacking predictor plus the queue of entries it expects, oldest first.
   class entry_scoreboard;
      int unsigned  palette_count;
      int unsigned  extent_x, extent_y, extent_z;
      int unsigned  byte_budget;
      logic [63:0]  gathered_word;
      int unsigned  slot_count;
      int unsigned  spill_bits;
      int unsigned  spill_count;
      int unsigned  entries_out;
      bit           array_checked;
      bit           array_faulted;
      rsp_data_type pending[$];
      int           mismatches;

      function new();
         palette_count = 2;
         extent_x      = 1;
         extent_y      = 1;
         extent_z      = 1;
         byte_budget   = 0;
         mismatches    = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         gathered_word = '0;
         slot_count    = 0;
         spill_bits    = 0;
         spill_count   = 0;
         entries_out   = 0;
         array_checked = 0;
         array_faulted = 0;
      endfunction

      // Append one predicted result behind the ones already waiting.
      function void queue_entry(rsp_data_type res);
         pending.insert(pending.size(), res);
      endfunction

      function longint unsigned ones(int unsigned n);
         return (n >= 64) ? ~64'd0 : ((64'd1 << n) - 64'd1);
      endfunction

      // Smallest width whose id space covers the palette; zero when out of range.
      function int unsigned entry_bits();
         if (palette_count < 2) return 0;
         for (int unsigned w = 1; w <= MAX_ENTRY_BITS; w++) begin
            if ((64'd1 << w) >= 64'(palette_count)) return w;
         end
         return 0;
      endfunction

      function longint unsigned volume();
         return longint'(extent_x) * extent_y * extent_z;
      endfunction

      function err_code_type judge_settings();
         longint unsigned need;
         longint unsigned bits;
         int unsigned     w;
         w = entry_bits();
         if (w == 0) return ERR_PALETTE;
         if (extent_x == 0 || extent_y == 0 || extent_z == 0) return ERR_ZERO_SIZE;
         if (byte_budget == 0) return ERR_NO_DATA;
         need = volume() * w;
         bits = longint'(byte_budget) * 8;
         if (bits < need) return ERR_SHORT;
         if (bits > need + WORD_BITS) return ERR_LONG;
         return ERR_NONE;
      endfunction

      // Cut nbits of word into entries, joining the bits left over from the last word.
      function void split_word(logic [63:0] word, int unsigned nbits);
         int unsigned     w;
         longint unsigned vol;
         int unsigned     wpos;
         int unsigned     need;
         int unsigned     rest;
         int              produced;
         int unsigned     part;
         int unsigned     value;
         rsp_data_type    res;
         w        = entry_bits();
         vol      = volume();
         wpos     = 0;
         produced = 0;
         if (w == 0) return;
         while (entries_out < vol && produced < 64 && spill_count + (nbits - wpos) >= w) begin
            need = w - spill_count;
            part = 0;
            if (need > 0 && wpos < 64) part = 32'((word >> wpos) & ones(need));
            value = (spill_bits | (part << spill_count)) & 32'(ones(w)) & 32'hFFFF;
            wpos += need;
            spill_bits  = 0;
            spill_count = 0;
            entries_out++;
            res.entry_value = value[15:0];
            res.last_entry  = (entries_out == vol);
            res.error_code  = ERR_NONE;
            queue_entry(res);
            produced++;
         end
         if (entries_out >= vol) begin
            spill_bits  = 0;
            spill_count = 0;
            return;
         end
         rest = nbits - wpos;
         if (rest > 0 && wpos < 64) begin
            spill_bits |= 32'((word >> wpos) & ones(rest)) << spill_count;
            spill_count += rest;
         end
         spill_bits  &= 32'h7FFF;
         spill_count &= 32'hF;
      endfunction

      function void configure(logic [2:0] idx, logic [23:0] val);
         case (idx)
            CSR_PALETTE_SIZE: palette_count = val[16:0];
            CSR_SIZE_X:       extent_x      = val[9:0];
            CSR_SIZE_Y:       extent_y      = val[9:0];
            CSR_SIZE_Z:       extent_z      = val[9:0];
            CSR_DATA_LENGTH:  byte_budget   = val;
            default:          return;
         endcase
         clear_stream();
      endfunction

      // Note one accepted request and queue the entries it must yield.
      function void note_request(req_data_type req);
         err_code_type code;
         rsp_data_type res;
         if (!array_checked) begin
            code          = judge_settings();
            array_checked = 1;
            if (code != ERR_NONE) begin
               array_faulted   = 1;
               res.entry_value = '0;
               res.last_entry  = 1'b1;
               res.error_code  = code;
               queue_entry(res);
            end
         end
         if (!array_faulted) begin
            gathered_word = {gathered_word[55:0], req.data_byte};
            slot_count++;
            if (slot_count >= 8) begin
               split_word(gathered_word, WORD_BITS);
               gathered_word = '0;
               slot_count    = 0;
            end else if (req.final_byte) begin
               split_word(gathered_word, slot_count * 8);
            end
         end
         if (req.final_byte) clear_stream();
      endfunction

      function void check_result(rsp_data_type got);
         rsp_data_type want;
         if (pending.size() == 0) begin
            $error("unexpected entry: value %0h last %0b code %0d",
                   got.entry_value, got.last_entry, got.error_code);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (got.entry_value !== want.entry_value) begin
            $error("entry_value expected %0h actual %0h", want.entry_value, got.entry_value);
            mismatches++;
         end
         if (got.last_entry !== want.last_entry) begin
            $error("last_entry expected %0b actual %0b", want.last_entry, got.last_entry);
            mismatches++;
         end
         if (got.error_code !== want.error_code) begin
            $error("error_code expected %0d actual %0d", want.error_code, got.error_code);
            mismatches++;
         end
      endfunction
   endclass

   logic         clock        = 1'b0;
   logic         reset        = 1'b1;
   logic         req_valid    = 1'b0;
   logic         req_stall;
   req_data_type req_data     = '0;
   logic         rsp_valid;
   logic         rsp_stall    = 1'b0;
   rsp_data_type rsp_data;
   logic         csr_write_en = 1'b0;
   logic [2:0]   csr_index    = '0;
   logic [23:0]  csr_wdata    = '0;

   entry_scoreboard board;
   int  cycle_count   = 0;
   int  requests_sent = 0;
   int  burst_left    = 0;
   bit  hold_off_req  = 0;
   int  hold_left     = 0;
   int  stall_mode    = 0;
   int  mode_left     = 0;

   packed_index_unpacker_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Guard the run: a hang or a lost entry ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Check every entry the block hands over against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // Receiver: switch at random between never, light and heavy stalling;
   // on request hold off completely for a long stretch.
   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_left    = HOLD_OFF_LEN;
         hold_off_req = 0;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Offer one request and hold it until accepted; sometimes insert a gap between bursts.
   task automatic send_request(input logic [7:0] data, input logic last_flag);
      req_data_type item;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      item.data_byte  = data;
      item.final_byte = last_flag;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_request(item);
      requests_sent++;
   endtask

   // Drop valid, let every predicted entry drain, then give trailing bytes time to retire.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [23:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      board.configure(idx, val);
   endtask

   // Sometimes put junk above a register's width; the block must drop it.
   function automatic logic [23:0] with_junk(input int unsigned val, input int width);
      logic [23:0] v;
      v = 24'(val);
      if ($urandom_range(0, 3) == 0) v |= 24'($urandom) << width;
      return v;
   endfunction

   // Program all registers back to back, now and then with a write past the list.
   task automatic program_settings(input int unsigned palette, input int unsigned ext_x,
                                   input int unsigned ext_y, input int unsigned ext_z,
                                   input int unsigned length);
      logic [2:0] stray;
      wait_drained();
      write_csr(CSR_PALETTE_SIZE, with_junk(palette, 17));
      write_csr(CSR_SIZE_X, with_junk(ext_x, 10));
      write_csr(CSR_SIZE_Y, with_junk(ext_y, 10));
      write_csr(CSR_SIZE_Z, with_junk(ext_z, 10));
      write_csr(CSR_DATA_LENGTH, 24'(length));
      if ($urandom_range(0, 4) == 0) begin
         stray = CSR_DATA_LENGTH + 3'($urandom_range(1, 3));
         write_csr(stray, 24'($urandom));
      end
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_array(input int count, input bit closed);
      for (int i = 0; i < count; i++) send_request(pick_byte(), closed && (i == count - 1));
   endtask

   // One setting and a few arrays under it; force_good skips the faulty settings.
   task automatic run_phase(input bit force_good);
      int unsigned     w, palette, ext_x, ext_y, ext_z, length;
      longint unsigned need, lo, hi;
      int              kind, shape, count;
      w       = $urandom_range(1, MAX_ENTRY_BITS);
      palette = (w == 1) ? 2 : $urandom_range((1 << (w - 1)) + 1, 1 << w);
      ext_x   = $urandom_range(1, 6);
      ext_y   = $urandom_range(1, 3);
      ext_z   = $urandom_range(1, 2);
      if ($urandom_range(0, 24) == 0) begin
         // one long row of one-bit ids: a word's worth of entries per word
         w = 1; palette = 2; ext_x = 1023; ext_y = 1; ext_z = 1;
      end
      need   = longint'(ext_x) * ext_y * ext_z * w;
      lo     = (need + 7) / 8;
      hi     = (need + WORD_BITS) / 8;
      length = $urandom_range(int'(lo), int'(hi));
      kind   = force_good ? 9 : $urandom_range(0, 11);
      case (kind)
         0: begin
            case ($urandom_range(0, 2))
               0:       palette = 0;
               1:       palette = 1;
               default: palette = $urandom_range(65537, 131071);
            endcase
         end
         1: begin
            case ($urandom_range(0, 2))
               0:       ext_x = 0;
               1:       ext_y = 0;
               default: ext_z = 0;
            endcase
         end
         2: length = (lo > 1) ? $urandom_range(0, int'(lo) - 1) : 0;
         3: length = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF
                                                 : int'(hi) + $urandom_range(1, 40);
         4: begin
            palette = 65536; ext_x = 1023; ext_y = 1023; ext_z = 1023; length = 24'hFFFFFF;
         end
         default: ;
      endcase
      program_settings(palette, ext_x, ext_y, ext_z, length);
      if (force_good) hold_off_req = 1;
      repeat ($urandom_range(1, 3)) begin
         if (kind <= 4) begin
            send_array($urandom_range(1, 4), $urandom_range(0, 1));
         end else begin
            shape = $urandom_range(0, 9);
            if (shape <= 5)       send_array(length, 1);
            else if (shape <= 7)  send_array((length > 1) ? $urandom_range(1, length - 1) : 1, 1);
            else if (shape == 8)  send_array(length + $urandom_range(1, 9), 1);
            else                  send_array(length, 0);
         end
      end
   endtask

   initial begin
      int directed_count;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings announce no data: one error, then the next byte is dropped.
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b1);

      // Palette out of range on both sides, including the widest field value.
      program_settings(0, 1, 1, 1, 8);
      send_request(8'hFF, 1'b1);
      program_settings(1, 1, 1, 1, 8);
      send_request(8'h00, 1'b1);
      program_settings(65537, 1, 1, 1, 8);
      send_request(8'h80, 1'b1);
      program_settings(131071, 1, 1, 1, 8);
      send_request(8'h01, 1'b1);

      // Zero extent, largest extents with too little data, and far too much data.
      program_settings(65536, 0, 1, 1, 8);
      send_request(8'h7F, 1'b1);
      program_settings(65536, 1023, 1023, 1023, 24'hFFFFFF);
      send_request(8'hFE, 1'b1);
      program_settings(65536, 1, 1, 4, 24'hFFFFFF);
      send_request(8'h00, 1'b1);

      // Full 16-bit ids: one word, four entries, then a surplus byte that yields nothing.
      program_settings(65536, 1, 1, 4, 8);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'h80, 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'h7F, 1'b0);
      send_request(8'hFE, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h55, 1'b1);

      // Three-bit ids: a short last word of two bytes, then an array cut off early.
      program_settings(8, 3, 1, 1, 2);
      send_request(8'hA5, 1'b0);
      send_request(8'h3C, 1'b1);
      send_request(8'hC3, 1'b1);

      // Random part; the first phase starts with the receiver held off.
      directed_count = requests_sent;
      run_phase(1);
      while (requests_sent < directed_count + RANDOM_TARGET) run_phase(0);

      wait_drained();
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
